[rtl/assert_macros.svh]
// assertion macros for the classifier
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define AST_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/apc_pkg.sv]
// package with types, codes and constants of the protocol classifier
`timescale 1ns / 1ps
package apc_pkg;

  localparam int MAX_PAYLOAD_DEF = 65535;

  localparam logic [2:0] CLS_UNKNOWN = 3'd0;
  localparam logic [2:0] CLS_TLS     = 3'd1;
  localparam logic [2:0] CLS_HTTP    = 3'd2;
  localparam logic [2:0] CLS_DNS     = 3'd3;
  localparam logic [2:0] CLS_QUIC    = 3'd4;

  localparam logic       REG_DNS_PORT  = 1'b0;
  localparam logic       REG_QUIC_PORT = 1'b1;
  localparam logic [15:0] DNS_PORT_RST  = 16'd53;
  localparam logic [15:0] QUIC_PORT_RST = 16'd443;

  localparam logic [15:0] TLS_SID_POS   = 16'd43;
  localparam logic [7:0]  TLS_HANDSHAKE = 8'h16;
  localparam logic [7:0]  TLS_MAJOR     = 8'h03;
  localparam logic [7:0]  TLS_HELLO     = 8'h01;

  localparam logic [31:0] HTTP_GET    = "GET ";
  localparam logic [31:0] HTTP_POST   = "POST";
  localparam logic [31:0] HTTP_PUT    = "PUT ";
  localparam logic [31:0] HTTP_HEAD   = "HEAD";
  localparam logic [47:0] HTTP_DELETE = "DELETE";
  localparam logic [39:0] HTTP_RESP   = "HTTP/";

  localparam logic [7:0] CHAR_H  = "H";
  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;
  localparam logic [2:0] HOST_KEY_LEN = 3'd6;

  localparam logic [7:0]  DNS_QR_MASK  = 8'h80;
  localparam logic [7:0]  QUIC_LONG    = 8'h80;
  localparam logic [31:0] QUIC_V1      = 32'h0000_0001;
  localparam logic [31:0] QUIC_V2      = 32'h6b33_43cf;
  localparam logic [31:0] QUIC_DRAFT   = 32'hff00_0000;

  typedef enum logic [3:0] {
    TP_SID, TP_CIPH_HI, TP_CIPH_LO, TP_COMP, TP_EXTL_HI, TP_EXTL_LO,
    TP_TYPE_HI, TP_TYPE_LO, TP_DLEN_HI, TP_DLEN_LO, TP_NAME_HI, TP_NAME_LO, TP_DONE
  } tls_phase_t;

  typedef enum logic [1:0] {HP_SEARCH, HP_VALUE, HP_DONE} host_phase_t;

  typedef struct packed {
    logic        take;
    logic        restart;
    logic        active;
    logic        last;
    logic [15:0] pos;
    logic [7:0]  data;
  } byte_ctl_t;

  typedef struct packed {
    logic        seen;
    logic [15:0] start;
    logic [15:0] len;
  } tls_info_t;

  typedef struct packed {
    host_phase_t phase;
    logic [15:0] start;
    logic [15:0] end_pos;
  } host_info_t;

  typedef struct packed {
    logic [2:0]  app_class;
    logic        name_found;
    logic [16:0] name_offset;
    logic [15:0] name_length;
    logic [15:0] dns_id;
    logic [7:0]  dns_flag_byte;
    logic [15:0] dns_questions;
  } result_t;

  function automatic logic [7:0] host_key(input logic [2:0] idx);
    logic [7:0] k;
    case (idx)
      3'd0: k = "H";
      3'd1: k = "o";
      3'd2: k = "s";
      3'd3: k = "t";
      3'd4: k = ":";
      3'd5: k = " ";
      default: k = "H";
    endcase
    return k;
  endfunction

endpackage

[rtl/apc_byte_if.sv]
// input channel: one payload byte with packet marks and ports
`timescale 1ns / 1ps
interface apc_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        first_byte;
  logic        last_byte;
  logic [15:0] payload_start;
  logic [15:0] source_port;
  logic [15:0] destination_port;

  modport source (output valid, payload_byte, first_byte, last_byte, payload_start,
                  source_port, destination_port, input ready);
  modport sink (input valid, payload_byte, first_byte, last_byte, payload_start,
                source_port, destination_port, output ready);
endinterface

[rtl/apc_result_if.sv]
// output channel: one classification word per packet
`timescale 1ns / 1ps
interface apc_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  app_class;
  logic        name_found;
  logic [16:0] name_offset;
  logic [15:0] name_length;
  logic [15:0] dns_id;
  logic [7:0]  dns_flag_byte;
  logic [15:0] dns_questions;

  modport source (output valid, app_class, name_found, name_offset, name_length, dns_id,
                  dns_flag_byte, dns_questions, input ready);
  modport sink (input valid, app_class, name_found, name_offset, name_length, dns_id,
                dns_flag_byte, dns_questions, output ready);
endinterface

[rtl/apc_tls.sv]
// tls clienthello walker that locates the server name
`timescale 1ns / 1ps
module apc_tls (
  input  logic                clk,
  input  logic                rst,
  input  apc_pkg::byte_ctl_t  ctl,
  output apc_pkg::tls_info_t  info
);

  apc_pkg::tls_phase_t phase, phase_cur, phase_next;
  logic [16:0] skip, skip_cur, skip_next;
  logic [7:0]  field, field_cur, field_next;
  logic [15:0] sni_start, sni_start_cur, sni_start_next;
  logic [15:0] sni_length, sni_length_cur, sni_length_next;
  logic        sni_seen, sni_seen_cur, sni_seen_next;
  logic [16:0] pos17, data17, word17;
  logic        hit;

  always_comb begin
    phase_cur      = ctl.restart ? apc_pkg::TP_SID : phase;
    skip_cur       = ctl.restart ? 17'd0 : skip;
    field_cur      = ctl.restart ? 8'd0 : field;
    sni_start_cur  = ctl.restart ? 16'd0 : sni_start;
    sni_length_cur = ctl.restart ? 16'd0 : sni_length;
    sni_seen_cur   = ctl.restart ? 1'b0 : sni_seen;
    pos17  = {1'b0, ctl.pos};
    data17 = {9'd0, ctl.data};
    word17 = {1'b0, field_cur, ctl.data};
    hit    = ctl.active && phase_cur != apc_pkg::TP_SID && phase_cur != apc_pkg::TP_DONE &&
             pos17 == skip_cur;
  end

  // phase sequence
  always_comb begin
    phase_next = phase_cur;
    if (ctl.active && phase_cur == apc_pkg::TP_SID && ctl.pos == apc_pkg::TLS_SID_POS) begin
      phase_next = apc_pkg::TP_CIPH_HI;
    end else if (hit) begin
      unique case (phase_cur)
        apc_pkg::TP_CIPH_HI: phase_next = apc_pkg::TP_CIPH_LO;
        apc_pkg::TP_CIPH_LO: phase_next = apc_pkg::TP_COMP;
        apc_pkg::TP_COMP:    phase_next = apc_pkg::TP_EXTL_HI;
        apc_pkg::TP_EXTL_HI: phase_next = apc_pkg::TP_EXTL_LO;
        apc_pkg::TP_EXTL_LO: phase_next = apc_pkg::TP_TYPE_HI;
        apc_pkg::TP_TYPE_HI: phase_next = apc_pkg::TP_TYPE_LO;
        apc_pkg::TP_TYPE_LO: phase_next = (word17 == 17'd0) ? apc_pkg::TP_NAME_HI
                                                            : apc_pkg::TP_DLEN_HI;
        apc_pkg::TP_DLEN_HI: phase_next = apc_pkg::TP_DLEN_LO;
        apc_pkg::TP_DLEN_LO: phase_next = apc_pkg::TP_TYPE_HI;
        apc_pkg::TP_NAME_HI: phase_next = apc_pkg::TP_NAME_LO;
        apc_pkg::TP_NAME_LO: phase_next = apc_pkg::TP_DONE;
        default:             phase_next = phase_cur;
      endcase
    end
  end

  // skip pointer, field byte and name capture
  always_comb begin
    skip_next       = skip_cur;
    field_next      = field_cur;
    sni_start_next  = sni_start_cur;
    sni_length_next = sni_length_cur;
    sni_seen_next   = sni_seen_cur;
    if (ctl.active && phase_cur == apc_pkg::TP_SID && ctl.pos == apc_pkg::TLS_SID_POS) begin
      skip_next = pos17 + 17'd1 + data17;
    end else if (hit) begin
      unique case (phase_cur)
        apc_pkg::TP_CIPH_HI, apc_pkg::TP_TYPE_HI, apc_pkg::TP_DLEN_HI,
        apc_pkg::TP_NAME_HI: begin
          field_next = ctl.data;
          skip_next  = pos17 + 17'd1;
        end
        apc_pkg::TP_CIPH_LO, apc_pkg::TP_DLEN_LO: skip_next = pos17 + 17'd1 + word17;
        apc_pkg::TP_COMP: skip_next = pos17 + 17'd1 + data17;
        apc_pkg::TP_EXTL_HI, apc_pkg::TP_EXTL_LO: skip_next = pos17 + 17'd1;
        apc_pkg::TP_TYPE_LO: skip_next = (word17 == 17'd0) ? pos17 + 17'd6 : pos17 + 17'd1;
        apc_pkg::TP_NAME_LO: begin
          sni_start_next  = ctl.pos + 16'd1;
          sni_length_next = word17[15:0];
          sni_seen_next   = 1'b1;
        end
        default: skip_next = skip_cur;
      endcase
    end
  end

  assign info.seen  = sni_seen_next;
  assign info.start = sni_start_next;
  assign info.len   = sni_length_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= apc_pkg::TP_SID;
      skip <= '0;
      field <= '0;
      sni_start <= '0;
      sni_length <= '0;
      sni_seen <= 1'b0;
    end else if (ctl.take) begin
      if (ctl.last) begin
        phase <= apc_pkg::TP_SID;
        skip <= '0;
        field <= '0;
        sni_start <= '0;
        sni_length <= '0;
        sni_seen <= 1'b0;
      end else begin
        phase <= phase_next;
        skip <= skip_next;
        field <= field_next;
        sni_start <= sni_start_next;
        sni_length <= sni_length_next;
        sni_seen <= sni_seen_next;
      end
    end
  end

endmodule

[rtl/apc_host.sv]
// http host header matcher
`timescale 1ns / 1ps
module apc_host (
  input  logic                clk,
  input  logic                rst,
  input  apc_pkg::byte_ctl_t  ctl,
  output apc_pkg::host_info_t info
);

  apc_pkg::host_phase_t phase, phase_cur, phase_next;
  logic [2:0]  match, match_cur, match_next, match_inc;
  logic [15:0] start, start_cur, start_next;
  logic [15:0] end_pos, end_cur, end_next;
  logic        key_hit, lf_hit;

  always_comb begin
    phase_cur = ctl.restart ? apc_pkg::HP_SEARCH : phase;
    match_cur = ctl.restart ? 3'd0 : match;
    start_cur = ctl.restart ? 16'd0 : start;
    end_cur   = ctl.restart ? 16'd0 : end_pos;
    match_inc = match_cur + 3'd1;
    key_hit   = ctl.data == apc_pkg::host_key(match_cur);
    lf_hit    = match_cur != 3'd0 && ctl.data == apc_pkg::CHAR_LF;
  end

  always_comb begin
    phase_next = phase_cur;
    if (ctl.active) begin
      unique case (phase_cur)
        apc_pkg::HP_SEARCH: begin
          if (key_hit && match_inc == apc_pkg::HOST_KEY_LEN) phase_next = apc_pkg::HP_VALUE;
        end
        apc_pkg::HP_VALUE: begin
          if (lf_hit) phase_next = apc_pkg::HP_DONE;
        end
        default: phase_next = phase_cur;
      endcase
    end
  end

  always_comb begin
    match_next = match_cur;
    start_next = start_cur;
    end_next   = end_cur;
    if (ctl.active) begin
      case (phase_cur)
        apc_pkg::HP_SEARCH: begin
          if (key_hit) begin
            if (match_inc == apc_pkg::HOST_KEY_LEN) begin
              match_next = 3'd0;
              start_next = ctl.pos + 16'd1;
            end else begin
              match_next = match_inc;
            end
          end else begin
            match_next = {2'b00, ctl.data == apc_pkg::CHAR_H};
          end
        end
        apc_pkg::HP_VALUE: begin
          if (lf_hit) end_next = ctl.pos - 16'd1;
          else match_next = {2'b00, ctl.data == apc_pkg::CHAR_CR};
        end
        default: match_next = match_cur;
      endcase
    end
  end

  assign info.phase   = phase_next;
  assign info.start   = start_next;
  assign info.end_pos = end_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= apc_pkg::HP_SEARCH;
      match <= '0;
      start <= '0;
      end_pos <= '0;
    end else if (ctl.take) begin
      if (ctl.last) begin
        phase <= apc_pkg::HP_SEARCH;
        match <= '0;
        start <= '0;
        end_pos <= '0;
      end else begin
        phase <= phase_next;
        match <= match_next;
        start <= start_next;
        end_pos <= end_next;
      end
    end
  end

endmodule

[rtl/apc_outq.sv]
// two-entry result buffer: output register plus skid stage
`timescale 1ns / 1ps
module apc_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  apc_pkg::result_t  push_data,
  output logic              push_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output apc_pkg::result_t  out_data
);

  logic             ov, ov_next, sv, sv_next;
  apc_pkg::result_t o_data, o_data_next, s_data, s_data_next;

  always_comb begin
    ov_next     = ov;
    sv_next     = sv;
    o_data_next = o_data;
    s_data_next = s_data;
    if (!ov || out_ready) begin
      if (sv) begin
        o_data_next = s_data;
        ov_next     = 1'b1;
        sv_next     = 1'b0;
      end else if (push) begin
        o_data_next = push_data;
        ov_next     = 1'b1;
      end else begin
        ov_next = 1'b0;
      end
    end else if (push) begin
      s_data_next = push_data;
      sv_next     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else begin
      ov <= ov_next;
      sv <= sv_next;
    end
  end

  always_ff @(posedge clk) begin
    o_data <= o_data_next;
    s_data <= s_data_next;
  end

  assign push_ready = !sv;
  assign out_valid  = ov;
  assign out_data   = o_data;

endmodule

[rtl/app_protocol_classifier.sv]
// the result word is registered into the result buffer when its packet's last byte is accepted
// throughput: one payload byte per cycle when not stalled, set by the per-byte state update
// results go through a two-entry buffer; bytes stall only when both entries are full
// reset (rst, synchronous): clears packet state, buffer, and sets dns_port 53, quic_port 443
`timescale 1ns / 1ps
`include "assert_macros.svh"
module app_protocol_classifier #(
  parameter int MAX_PAYLOAD = apc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                clk,
  input  logic                rst,
  apc_byte_if.sink            bytes,
  apc_result_if.source        result,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);

  logic [15:0] dns_port, quic_port;
  logic [15:0] count, count_cur, count_upd;
  logic [7:0]  head [6];
  logic [7:0]  head_cur [6];
  logic [7:0]  hb [6];
  logic [15:0] ps, sp, dp, ps_cur, sp_cur, dp_cur;
  logic        take, restart, active, push_ready;
  apc_pkg::byte_ctl_t  ctl;
  apc_pkg::tls_info_t  tls_info;
  apc_pkg::host_info_t host_info;
  apc_pkg::result_t    res, out_data;
  logic        is_tls, is_http, is_dns, is_quic;
  logic [16:0] sni_end;
  logic [15:0] http_len;
  logic [31:0] quic_ver;

  assign take    = bytes.valid && push_ready;
  assign restart = bytes.first_byte || count == 16'd0;
  assign count_cur = restart ? 16'd0 : count;
  assign active  = count_cur < 16'(MAX_PAYLOAD);
  assign count_upd = active ? count_cur + 16'd1 : count_cur;
  assign bytes.ready = push_ready;

  assign ps_cur = restart ? bytes.payload_start : ps;
  assign sp_cur = restart ? bytes.source_port : sp;
  assign dp_cur = restart ? bytes.destination_port : dp;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      head_cur[i] = restart ? 8'd0 : head[i];
      hb[i] = (active && count_cur == 16'(i)) ? bytes.payload_byte : head_cur[i];
    end
  end

  assign ctl.take    = take;
  assign ctl.restart = restart;
  assign ctl.active  = active;
  assign ctl.last    = bytes.last_byte;
  assign ctl.pos     = count_cur;
  assign ctl.data    = bytes.payload_byte;

  apc_tls u_tls (.clk(clk), .rst(rst), .ctl(ctl), .info(tls_info));
  apc_host u_host (.clk(clk), .rst(rst), .ctl(ctl), .info(host_info));

  always_comb begin
    sni_end  = {1'b0, tls_info.start} + {1'b0, tls_info.len};
    quic_ver = {hb[1], hb[2], hb[3], hb[4]};
    http_len = 16'd0;
    if (host_info.phase == apc_pkg::HP_VALUE && host_info.start < count_upd) begin
      http_len = count_upd - host_info.start;
    end else if (host_info.phase == apc_pkg::HP_DONE) begin
      http_len = host_info.end_pos - host_info.start;
    end
    is_tls = count_upd >= 16'd5 && hb[0] == apc_pkg::TLS_HANDSHAKE &&
             hb[1] == apc_pkg::TLS_MAJOR && hb[2] >= 8'd1 && hb[2] <= 8'd3;
    is_http = (count_upd >= 16'd4 && ({hb[0], hb[1], hb[2], hb[3]} == apc_pkg::HTTP_GET ||
                                      {hb[0], hb[1], hb[2], hb[3]} == apc_pkg::HTTP_POST ||
                                      {hb[0], hb[1], hb[2], hb[3]} == apc_pkg::HTTP_PUT ||
                                      {hb[0], hb[1], hb[2], hb[3]} == apc_pkg::HTTP_HEAD)) ||
              (count_upd >= 16'd6 &&
               {hb[0], hb[1], hb[2], hb[3], hb[4], hb[5]} == apc_pkg::HTTP_DELETE) ||
              (count_upd >= 16'd5 &&
               {hb[0], hb[1], hb[2], hb[3], hb[4]} == apc_pkg::HTTP_RESP);
    is_dns = (sp_cur == dns_port || dp_cur == dns_port) && count_upd >= 16'd12 &&
             ({hb[4], hb[5]} != 16'd0 || (hb[2] & apc_pkg::DNS_QR_MASK) != 8'd0);
    is_quic = count_upd >= 16'd5 && (hb[0] & apc_pkg::QUIC_LONG) != 8'd0 &&
              dp_cur == quic_port &&
              (quic_ver == apc_pkg::QUIC_V1 || quic_ver == apc_pkg::QUIC_V2 ||
               (quic_ver & apc_pkg::QUIC_DRAFT) == apc_pkg::QUIC_DRAFT);

    res = '0;
    if (is_tls) begin
      res.app_class = apc_pkg::CLS_TLS;
      if (count_upd > 16'd9 && hb[5] == apc_pkg::TLS_HELLO && tls_info.seen &&
          sni_end <= {1'b0, count_upd}) begin
        res.name_found  = 1'b1;
        res.name_offset = {1'b0, ps_cur} + {1'b0, tls_info.start};
        res.name_length = tls_info.len;
      end
    end else if (is_http) begin
      res.app_class = apc_pkg::CLS_HTTP;
      if (http_len != 16'd0) begin
        res.name_found  = 1'b1;
        res.name_offset = {1'b0, ps_cur} + {1'b0, host_info.start};
        res.name_length = http_len;
      end
    end else if (is_dns) begin
      res.app_class     = apc_pkg::CLS_DNS;
      res.dns_id        = {hb[0], hb[1]};
      res.dns_flag_byte = hb[2];
      res.dns_questions = {hb[4], hb[5]};
    end else if (is_quic) begin
      res.app_class = apc_pkg::CLS_QUIC;
    end else begin
      res.app_class = apc_pkg::CLS_UNKNOWN;
    end
  end

  apc_outq u_outq (
    .clk(clk), .rst(rst),
    .push(take && bytes.last_byte), .push_data(res), .push_ready(push_ready),
    .out_valid(result.valid), .out_ready(result.ready), .out_data(out_data)
  );

  assign result.app_class     = out_data.app_class;
  assign result.name_found    = out_data.name_found;
  assign result.name_offset   = out_data.name_offset;
  assign result.name_length   = out_data.name_length;
  assign result.dns_id        = out_data.dns_id;
  assign result.dns_flag_byte = out_data.dns_flag_byte;
  assign result.dns_questions = out_data.dns_questions;

  always_ff @(posedge clk) begin
    if (rst) begin
      dns_port  <= apc_pkg::DNS_PORT_RST;
      quic_port <= apc_pkg::QUIC_PORT_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == apc_pkg::REG_DNS_PORT) dns_port <= cfg_data;
      else quic_port <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ps <= '0;
      sp <= '0;
      dp <= '0;
      for (int i = 0; i < 6; i++) head[i] <= '0;
    end else if (take) begin
      count <= bytes.last_byte ? 16'd0 : count_upd;
      ps <= ps_cur;
      sp <= sp_cur;
      dp <= dp_cur;
      for (int i = 0; i < 6; i++) head[i] <= bytes.last_byte ? 8'd0 : hb[i];
    end
  end

  `AST_NEXT(a_last_gives_word, bytes.valid && bytes.ready && bytes.last_byte, result.valid)
  `AST_IMPLY(a_name_only_named, result.valid && result.app_class != apc_pkg::CLS_TLS && result.app_class != apc_pkg::CLS_HTTP, !result.name_found && result.name_length == 16'd0)
  `AST_IMPLY(a_dns_only_dns, result.valid && result.app_class != apc_pkg::CLS_DNS, result.dns_id == 16'd0 && result.dns_questions == 16'd0)

endmodule

[sim/tb_top.sv]
// testbench for the protocol classifier: packet stimulus, byte-level predictor, result checks
`timescale 1ns / 1ps
module tb_top;

  localparam int MAXP = 65535;
  localparam int IDLE_LIMIT = 3000;

  typedef struct {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [15:0] ps;
    logic [15:0] sp;
    logic [15:0] dp;
  } byte_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = apc_pkg::REG_DNS_PORT;
  logic [15:0] cfg_data = '0;

  apc_byte_if bi();
  apc_result_if ro();

  app_protocol_classifier dut (
    .clk(clk), .rst(rst), .bytes(bi), .result(ro),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [15:0] dns_port_m, quic_port_m;
  int unsigned cnt, tskip, tfield, sni_st, sni_len, hstart, hend;
  logic [7:0]  hd [6];
  apc_pkg::tls_phase_t  tph;
  logic        sni_ok;
  int unsigned hmatch;
  apc_pkg::host_phase_t hph;
  logic [15:0] lat_ps, lat_sp, lat_dp;
  logic [7:0]  host_chars [6] = '{"H", "o", "s", "t", ":", " "};

  apc_pkg::result_t expected_q [$];
  int fails = 0;
  int idle_cyc = 0;
  int hold_left = 0;
  bit rx_stall = 1'b1;
  bit tx_idle = 1'b1;
  int burst_left = 0;
  logic [7:0] pkt [$];

  task automatic clear_packet();
    cnt = 0; tph = apc_pkg::TP_SID; tskip = 0; tfield = 0;
    sni_st = 0; sni_len = 0; sni_ok = 0;
    hmatch = 0; hph = apc_pkg::HP_SEARCH; hstart = 0; hend = 0;
    foreach (hd[i]) hd[i] = '0;
  endtask

  task automatic tls_track(int unsigned p, int unsigned b);
    if (tph == apc_pkg::TP_SID) begin
      if (p == 43) begin tskip = p + 1 + b; tph = apc_pkg::TP_CIPH_HI; end
      return;
    end
    if (tph == apc_pkg::TP_DONE || p != tskip) return;
    case (tph)
      apc_pkg::TP_CIPH_HI: begin
        tfield = b << 8; tskip = p + 1; tph = apc_pkg::TP_CIPH_LO;
      end
      apc_pkg::TP_CIPH_LO: begin
        tskip = p + 1 + (tfield | b); tph = apc_pkg::TP_COMP;
      end
      apc_pkg::TP_COMP:    begin tskip = p + 1 + b; tph = apc_pkg::TP_EXTL_HI; end
      apc_pkg::TP_EXTL_HI: begin tskip = p + 1; tph = apc_pkg::TP_EXTL_LO; end
      apc_pkg::TP_EXTL_LO: begin tskip = p + 1; tph = apc_pkg::TP_TYPE_HI; end
      apc_pkg::TP_TYPE_HI: begin
        tfield = b << 8; tskip = p + 1; tph = apc_pkg::TP_TYPE_LO;
      end
      apc_pkg::TP_TYPE_LO: begin
        if ((tfield | b) == 0) begin tskip = p + 6; tph = apc_pkg::TP_NAME_HI; end
        else begin tskip = p + 1; tph = apc_pkg::TP_DLEN_HI; end
      end
      apc_pkg::TP_DLEN_HI: begin
        tfield = b << 8; tskip = p + 1; tph = apc_pkg::TP_DLEN_LO;
      end
      apc_pkg::TP_DLEN_LO: begin
        tskip = p + 1 + (tfield | b); tph = apc_pkg::TP_TYPE_HI;
      end
      apc_pkg::TP_NAME_HI: begin
        tfield = b << 8; tskip = p + 1; tph = apc_pkg::TP_NAME_LO;
      end
      apc_pkg::TP_NAME_LO: begin
        sni_st = p + 1; sni_len = tfield | b; sni_ok = 1'b1; tph = apc_pkg::TP_DONE;
      end
      default: ;
    endcase
    tskip = tskip & 32'h1ffff;
  endtask

  task automatic host_track(int unsigned p, logic [7:0] b);
    if (hph == apc_pkg::HP_SEARCH) begin
      if (b == host_chars[hmatch % 6]) begin
        hmatch++;
        if (hmatch == 6) begin hph = apc_pkg::HP_VALUE; hstart = p + 1; hmatch = 0; end
      end else begin
        hmatch = (b == apc_pkg::CHAR_H) ? 1 : 0;
      end
    end else if (hph == apc_pkg::HP_VALUE) begin
      if (hmatch != 0 && b == apc_pkg::CHAR_LF) begin hend = p - 1; hph = apc_pkg::HP_DONE; end
      else hmatch = (b == apc_pkg::CHAR_CR) ? 1 : 0;
    end
  endtask

  task automatic classify_byte(byte_word_t w);
    apc_pkg::result_t r;
    int unsigned len, v;
    if (w.first || cnt == 0) begin
      clear_packet();
      lat_ps = w.ps; lat_sp = w.sp; lat_dp = w.dp;
    end
    if (cnt < MAXP) begin
      if (cnt < 6) hd[cnt] = w.data;
      tls_track(cnt, w.data);
      host_track(cnt, w.data);
      cnt++;
    end
    if (!w.last) return;
    r = '0;
    r.app_class = apc_pkg::CLS_UNKNOWN;
    if (cnt >= 5 && hd[0] == apc_pkg::TLS_HANDSHAKE && hd[1] == apc_pkg::TLS_MAJOR &&
        hd[2] >= 1 && hd[2] <= 3) begin
      r.app_class = apc_pkg::CLS_TLS;
      if (cnt > 9 && hd[5] == apc_pkg::TLS_HELLO && sni_ok && sni_st + sni_len <= cnt) begin
        r.name_found = 1'b1;
        r.name_offset = 17'(lat_ps + sni_st);
        r.name_length = 16'(sni_len);
      end
    end else if ((cnt >= 4 && ({hd[0], hd[1], hd[2], hd[3]} == apc_pkg::HTTP_GET ||
                  {hd[0], hd[1], hd[2], hd[3]} == apc_pkg::HTTP_POST ||
                  {hd[0], hd[1], hd[2], hd[3]} == apc_pkg::HTTP_PUT ||
                  {hd[0], hd[1], hd[2], hd[3]} == apc_pkg::HTTP_HEAD)) ||
                 (cnt >= 6 &&
                  {hd[0], hd[1], hd[2], hd[3], hd[4], hd[5]} == apc_pkg::HTTP_DELETE) ||
                 (cnt >= 5 && {hd[0], hd[1], hd[2], hd[3], hd[4]} == apc_pkg::HTTP_RESP)) begin
      r.app_class = apc_pkg::CLS_HTTP;
      len = 0;
      if (hph == apc_pkg::HP_VALUE && hstart < cnt) len = cnt - hstart;
      else if (hph == apc_pkg::HP_DONE) len = hend - hstart;
      if (len != 0) begin
        r.name_found = 1'b1;
        r.name_offset = 17'(lat_ps + hstart);
        r.name_length = 16'(len);
      end
    end else if ((lat_sp == dns_port_m || lat_dp == dns_port_m) && cnt >= 12 &&
                 ({hd[4], hd[5]} != 0 || (hd[2] & apc_pkg::DNS_QR_MASK) != 0)) begin
      r.app_class = apc_pkg::CLS_DNS;
      r.dns_id = {hd[0], hd[1]};
      r.dns_flag_byte = hd[2];
      r.dns_questions = {hd[4], hd[5]};
    end else if (cnt >= 5 && (hd[0] & apc_pkg::QUIC_LONG) != 0 && lat_dp == quic_port_m) begin
      v = {hd[1], hd[2], hd[3], hd[4]};
      if (v == apc_pkg::QUIC_V1 || v == apc_pkg::QUIC_V2 ||
          (v & apc_pkg::QUIC_DRAFT) == apc_pkg::QUIC_DRAFT)
        r.app_class = apc_pkg::CLS_QUIC;
    end
    expected_q.push_back(r);
    clear_packet();
  endtask

  // byte acceptance and watchdog
  always @(posedge clk) begin
    byte_word_t w;
    if (!rst) begin
      if ((bi.valid && bi.ready) || (ro.valid && ro.ready)) idle_cyc = 0;
      else idle_cyc++;
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
      if (bi.valid && bi.ready) begin
        w.data = bi.payload_byte; w.first = bi.first_byte; w.last = bi.last_byte;
        w.ps = bi.payload_start; w.sp = bi.source_port; w.dp = bi.destination_port;
        classify_byte(w);
      end
    end
  end

  // result check
  always @(posedge clk) begin
    apc_pkg::result_t e;
    if (!rst && ro.valid && ro.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result word, class %0d", ro.app_class);
        fails++;
      end else begin
        e = expected_q.pop_front();
        if (ro.app_class !== e.app_class) begin
          $error("app_class exp %0d got %0d", e.app_class, ro.app_class); fails++;
        end
        if (ro.name_found !== e.name_found) begin
          $error("name_found exp %0d got %0d", e.name_found, ro.name_found); fails++;
        end
        if (ro.name_offset !== e.name_offset) begin
          $error("name_offset exp %0d got %0d", e.name_offset, ro.name_offset); fails++;
        end
        if (ro.name_length !== e.name_length) begin
          $error("name_length exp %0d got %0d", e.name_length, ro.name_length); fails++;
        end
        if (ro.dns_id !== e.dns_id) begin
          $error("dns_id exp %h got %h", e.dns_id, ro.dns_id); fails++;
        end
        if (ro.dns_flag_byte !== e.dns_flag_byte) begin
          $error("dns_flag_byte exp %h got %h", e.dns_flag_byte, ro.dns_flag_byte); fails++;
        end
        if (ro.dns_questions !== e.dns_questions) begin
          $error("dns_questions exp %h got %h", e.dns_questions, ro.dns_questions); fails++;
        end
      end
    end
  end

  // receiver stall pattern and long hold-off
  always @(posedge clk) begin
    if (rst) begin
      ro.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      ro.ready <= 1'b0;
    end else if (rx_stall) begin
      ro.ready <= ($urandom_range(0, 3) != 0);
    end else begin
      ro.ready <= 1'b1;
    end
  end

  task automatic send_byte(byte_word_t w);
    int g;
    if (tx_idle && burst_left == 0) begin
      g = $urandom_range(0, 5);
      burst_left = $urandom_range(1, 24);
      if (g > 0) begin
        bi.valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    bi.valid <= 1'b1;
    bi.payload_byte <= w.data; bi.first_byte <= w.first; bi.last_byte <= w.last;
    bi.payload_start <= w.ps; bi.source_port <= w.sp; bi.destination_port <= w.dp;
    do @(posedge clk); while (!bi.ready);
  endtask

  task automatic send_pkt(logic [15:0] ps, logic [15:0] sp, logic [15:0] dp,
                          bit mark_first, bit no_last);
    byte_word_t w;
    foreach (pkt[i]) begin
      w.data = pkt[i]; w.first = (i == 0) ? mark_first : 1'b0;
      w.last = (i == pkt.size() - 1) && !no_last;
      w.ps = ps; w.sp = sp; w.dp = dp;
      send_byte(w);
    end
  endtask

  task automatic drain();
    bi.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == apc_pkg::REG_DNS_PORT) dns_port_m = val; else quic_port_m = val;
  endtask

  task automatic push_str(string s);
    foreach (s[i]) pkt.push_back(s[i]);
  endtask

  task automatic push_rand(int n);
    repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic push16(int unsigned v);
    pkt.push_back(v[15:8]); pkt.push_back(v[7:0]);
  endtask

  task automatic build_tls(bit with_sni, int nlen);
    int sid, c, d;
    pkt = {};
    pkt.push_back(apc_pkg::TLS_HANDSHAKE); pkt.push_back(apc_pkg::TLS_MAJOR);
    pkt.push_back(8'($urandom_range(0, 7) == 0 ? $urandom_range(0, 255)
                                                : $urandom_range(1, 3)));
    push_rand(2);
    pkt.push_back($urandom_range(0, 7) == 0 ? 8'h02 : apc_pkg::TLS_HELLO);
    push_rand(37);
    sid = $urandom_range(0, 12);
    pkt.push_back(8'(sid)); push_rand(sid);
    c = 2 * $urandom_range(1, 4);
    push16(c); push_rand(c);
    pkt.push_back(8'd1); pkt.push_back(8'd0);
    push_rand(2);
    repeat ($urandom_range(0, 2)) begin
      pkt.push_back(8'($urandom_range(0, 255))); pkt.push_back(8'($urandom_range(1, 255)));
      d = $urandom_range(0, 6);
      push16(d); push_rand(d);
    end
    if (with_sni) begin
      push16(0); push_rand(5);
      push16(nlen);
      repeat (nlen) pkt.push_back(8'($urandom_range(8'h61, 8'h7a)));
    end
    push_rand($urandom_range(0, 3));
  endtask

  task automatic build_http(int kind, bit with_host, int ending);
    string methods [6] = '{"GET ", "POST", "PUT ", "HEAD", "DELETE", "HTTP/"};
    pkt = {};
    push_str(methods[kind]);
    push_str(" /a HTTP/1.1\r\n");
    if ($urandom_range(0, 1)) push_str("Hos: x\r\nHHost:\r\n");
    if (with_host) begin
      push_str("Host: ");
      repeat ($urandom_range(0, 10)) pkt.push_back(8'($urandom_range(8'h61, 8'h7a)));
      case (ending)
        0: ;
        1: push_str("\r\n");
        2: push_str("\rx\r\nAccept: y\r\n\r\n");
        default: push_str("\r");
      endcase
    end
  endtask

  task automatic build_dns(bit zero_qd);
    pkt = {};
    push_rand(4);
    push16(zero_qd ? 0 : $urandom_range(0, 65535));
    push_rand($urandom_range(4, 20));
  endtask

  task automatic build_quic(int ver);
    pkt = {};
    pkt.push_back(8'($urandom_range(0, 255)) | apc_pkg::QUIC_LONG);
    case (ver)
      0: begin push16(apc_pkg::QUIC_V1[31:16]); push16(apc_pkg::QUIC_V1[15:0]); end
      1: begin push16(apc_pkg::QUIC_V2[31:16]); push16(apc_pkg::QUIC_V2[15:0]); end
      2: begin pkt.push_back(8'hff); push_rand(3); end
      default: push_rand(4);
    endcase
    push_rand($urandom_range(0, 12));
  endtask

  function automatic logic [15:0] rand_port();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic test_directed();
    build_tls(1, 11); send_pkt(16'd14, 16'd5000, 16'd443, 1, 0);
    build_tls(1, 0);  send_pkt(16'hffff, 16'hffff, 16'h0000, 1, 0);
    build_tls(0, 0);  send_pkt(16'd0, 16'd1, 16'd2, 0, 0);
    for (int k = 0; k < 6; k++) begin
      build_http(k, 1, k % 4); send_pkt(16'd54, 16'd40000, 16'd80, 1, 0);
    end
    build_http(0, 0, 0); send_pkt(16'd0, 16'd1, 16'd80, 1, 0);
    build_dns(0); send_pkt(16'd42, 16'd53, 16'd999, 1, 0);
    build_dns(1); pkt[2] = 8'h80; send_pkt(16'd42, 16'd999, 16'd53, 1, 0);
    build_dns(1); pkt[2] = 8'h00; send_pkt(16'd42, 16'd53, 16'd53, 1, 0);
    for (int k = 0; k < 4; k++) begin
      build_quic(k); send_pkt(16'd42, 16'd7, 16'd443, 1, 0);
    end
    pkt = {8'h00}; send_pkt(16'd0, 16'd0, 16'd0, 1, 0);
    pkt = {8'hff}; send_pkt(16'hffff, 16'hffff, 16'hffff, 0, 0);
    // unfinished packet dropped by a new first byte
    build_http(0, 1, 1); send_pkt(16'd3, 16'd1, 16'd2, 1, 1);
    build_dns(0); send_pkt(16'd9, 16'd53, 16'd1, 1, 0);
    drain();
  endtask

  task automatic test_config();
    write_reg(apc_pkg::REG_DNS_PORT, 16'h0000);
    write_reg(apc_pkg::REG_QUIC_PORT, 16'hffff);
    build_dns(0); send_pkt(16'd1, 16'd0, 16'd5, 1, 0);
    build_quic(0); send_pkt(16'd1, 16'd5, 16'hffff, 1, 0);
    build_quic(0); send_pkt(16'd1, 16'd5, 16'd443, 1, 0);
    drain();
    write_reg(apc_pkg::REG_DNS_PORT, 16'hffff);
    write_reg(apc_pkg::REG_QUIC_PORT, 16'h0000);
    build_dns(0); send_pkt(16'd1, 16'd3, 16'hffff, 1, 0);
    build_quic(1); send_pkt(16'd1, 16'd5, 16'h0000, 1, 0);
    drain();
    write_reg(apc_pkg::REG_DNS_PORT, 16'd53);
    write_reg(apc_pkg::REG_QUIC_PORT, 16'd443);
  endtask

  task automatic test_pressure();
    hold_left = 400;
    repeat (20) begin
      build_quic(0); pkt = pkt[0:$urandom_range(0, 2)];
      send_pkt(rand_port(), rand_port(), 16'd443, 1, 0);
    end
    drain();
  endtask

  task automatic test_long_payload();
    tx_idle = 0;
    pkt = {};
    push_str("GET /");
    repeat (60) pkt.push_back(8'h61);
    push_str("\r\nHost: ");
    repeat (20) pkt.push_back(8'h62);
    send_pkt(16'hfff0, 16'd1, 16'd80, 1, 0);
    tx_idle = 1;
    drain();
  endtask

  task automatic test_random(int npk);
    int kind;
    logic [15:0] sp, dp;
    for (int n = 0; n < npk; n++) begin
      if (n % 40 == 20) begin
        rx_stall = 0; tx_idle = 0;
      end else if (n % 40 == 30) begin
        rx_stall = 1; tx_idle = 1;
      end
      if (n == npk / 2) begin
        drain();
        write_reg(apc_pkg::REG_DNS_PORT, 16'($urandom_range(0, 65535)));
        write_reg(apc_pkg::REG_QUIC_PORT, 16'($urandom_range(0, 65535)));
      end
      sp = rand_port(); dp = rand_port();
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: build_tls($urandom_range(0, 4) != 0, $urandom_range(0, 12));
        2, 3: build_http($urandom_range(0, 5), $urandom_range(0, 4) != 0,
                         $urandom_range(0, 3));
        4, 5: begin
          build_dns($urandom_range(0, 3) == 0);
          if ($urandom_range(0, 1)) sp = dns_port_m; else dp = dns_port_m;
        end
        6, 7: begin build_quic($urandom_range(0, 3)); dp = quic_port_m; end
        default: begin pkt = {}; push_rand($urandom_range(1, 20)); end
      endcase
      if ($urandom_range(0, 7) == 0) pkt = pkt[0:$urandom_range(0, pkt.size() - 1)];
      send_pkt(rand_port(), sp, dp, $urandom_range(0, 3) != 0,
               $urandom_range(0, 15) == 0);
    end
    drain();
  endtask

  initial begin
    bi.valid = 1'b0; bi.payload_byte = '0; bi.first_byte = 1'b0; bi.last_byte = 1'b0;
    bi.payload_start = '0; bi.source_port = '0; bi.destination_port = '0;
    dns_port_m = apc_pkg::DNS_PORT_RST; quic_port_m = apc_pkg::QUIC_PORT_RST;
    clear_packet();
    lat_ps = '0; lat_sp = '0; lat_dp = '0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config();
    test_pressure();
    test_long_payload();
    test_random(5);
    drain();
    repeat (8) @(posedge clk);
    if (fails == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
